// File: design/assert_macros.svh
// Assertion helpers shared by the stack modules.
// Both macros expect signals named clk and rst in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/mts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg
// Shared constants, codes and types of the minimum-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int STACK_DEPTH   = 256;
  localparam int DATA_WIDTH    = 32;
  localparam int ENTRY_WIDTH   = DATA_WIDTH + 2;
  localparam int ADDR_WIDTH    = $clog2(STACK_DEPTH);
  localparam int COUNT_WIDTH   = $clog2(STACK_DEPTH + 1);
  localparam int KIND_WIDTH    = 2;
  localparam int STATUS_WIDTH  = 2;

  localparam int S_TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int M_FIELD_BITS  = 2 * DATA_WIDTH + 1 + COUNT_WIDTH;
  localparam int M_TDATA_WIDTH = ((M_FIELD_BITS + 7) / 8) * 8;

  // Operation codes; any other code behaves as a peek.
  localparam logic [KIND_WIDTH-1:0] OP_PUSH = 2'd0;
  localparam logic [KIND_WIDTH-1:0] OP_POP  = 2'd1;
  localparam logic [KIND_WIDTH-1:0] OP_PEEK = 2'd2;

  // Result status codes.
  localparam logic [STATUS_WIDTH-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_OVERFLOW  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the operation and read the top entry
    logic execute;   // commit the operation and load the result register
  } mts_cmd_t;

endpackage

// File: design/mts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_ctrl
// Two-state sequencer and result valid flag of the minimum-tracking stack.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mts_ctrl
  import mts_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output mts_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_free;

  assign s_tready    = (state == S_IDLE);
  assign out_free    = !m_tvalid || m_tready;
  assign cmd.capture = s_tvalid && s_tready;
  assign cmd.execute = (state == S_EXEC) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.capture) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.execute) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.execute) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `ASSERT_ALWAYS(a_cmd_exclusive, !(cmd.capture && cmd.execute), "capture and execute together")
  `ASSERT_NEXT(a_capture_to_exec, cmd.capture, state == S_EXEC && !s_tready, "no execute after capture")
  `ASSERT_NEXT(a_exec_valid, cmd.execute, m_tvalid, "result not presented after execute")

endmodule

// File: design/mts_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_datapath
// Entry memory, fill level, running minimum and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mts_datapath
  import mts_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  mts_cmd_t                       cmd,
  input  logic        [KIND_WIDTH-1:0]   in_kind,
  input  logic signed [DATA_WIDTH-1:0]   in_value,
  output logic signed [DATA_WIDTH-1:0]   result_value,
  output logic signed [DATA_WIDTH-1:0]   min_value,
  output logic                           is_empty,
  output logic        [COUNT_WIDTH-1:0]  entry_count,
  output logic        [STATUS_WIDTH-1:0] status
);

  logic signed [ENTRY_WIDTH-1:0] mem [STACK_DEPTH];

  logic        [COUNT_WIDTH-1:0]  fill_level;
  logic        [COUNT_WIDTH-1:0]  fill_level_next;
  logic signed [DATA_WIDTH-1:0]   running_min;
  logic signed [DATA_WIDTH-1:0]   running_min_next;
  logic        [KIND_WIDTH-1:0]   op_kind;
  logic signed [DATA_WIDTH-1:0]   op_value;
  logic signed [ENTRY_WIDTH-1:0]  rd_data;

  logic        [ADDR_WIDTH-1:0]   rd_addr;
  logic        [ADDR_WIDTH-1:0]   wr_addr;
  logic                           mem_we;
  logic signed [ENTRY_WIDTH-1:0]  wr_data;
  logic signed [ENTRY_WIDTH-1:0]  v_ext;
  logic signed [ENTRY_WIDTH-1:0]  min_ext;
  logic signed [ENTRY_WIDTH-1:0]  encoded;
  logic signed [ENTRY_WIDTH-1:0]  restored;
  logic signed [DATA_WIDTH-1:0]   res_next;
  logic        [STATUS_WIDTH-1:0] status_next;
  logic                           stack_empty;
  logic                           stack_full;

  // The top entry sits one below the fill level; on an empty stack the
  // wrapped address is read but never used.
  assign rd_addr     = ADDR_WIDTH'(fill_level - COUNT_WIDTH'(1));
  assign wr_addr     = fill_level[ADDR_WIDTH-1:0];
  assign stack_empty = (fill_level == '0);
  assign stack_full  = (fill_level == COUNT_WIDTH'(STACK_DEPTH));

  assign v_ext    = ENTRY_WIDTH'(op_value);
  assign min_ext  = ENTRY_WIDTH'(running_min);
  assign encoded  = (v_ext <<< 1) - min_ext;
  assign restored = (min_ext <<< 1) - rd_data;

  always_comb begin
    fill_level_next  = fill_level;
    running_min_next = running_min;
    res_next         = op_value;
    status_next      = ST_OK;
    mem_we           = 1'b0;
    wr_data          = v_ext;
    if (op_kind == OP_PUSH) begin
      if (stack_full) begin
        status_next = ST_OVERFLOW;
      end else begin
        mem_we          = 1'b1;
        fill_level_next = fill_level + COUNT_WIDTH'(1);
        if (stack_empty) begin
          running_min_next = op_value;
        end else if (v_ext < min_ext) begin
          // A new minimum is stored encoded so the old one can be recovered.
          wr_data          = encoded;
          running_min_next = op_value;
        end
      end
    end else begin
      if (stack_empty) begin
        res_next    = '1;
        status_next = ST_UNDERFLOW;
      end else begin
        if (rd_data < min_ext) begin
          res_next = running_min;
          if (op_kind == OP_POP) running_min_next = DATA_WIDTH'(restored);
        end else begin
          res_next = DATA_WIDTH'(rd_data);
        end
        if (op_kind == OP_POP) fill_level_next = fill_level - COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_data <= mem[rd_addr];
    end
    if (cmd.execute && mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_kind  <= in_kind;
      op_value <= in_value;
    end
    if (cmd.execute) begin
      result_value <= res_next;
      min_value    <= (fill_level_next != '0) ? running_min_next : '1;
      is_empty     <= (fill_level_next == '0);
      entry_count  <= fill_level_next;
      status       <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_level  <= '0;
      running_min <= '0;
    end else if (cmd.execute) begin
      fill_level  <= fill_level_next;
      running_min <= running_min_next;
    end
  end

  `ASSERT_ALWAYS(a_fill_bound, fill_level <= COUNT_WIDTH'(STACK_DEPTH), "fill level past depth")
  `ASSERT_NEXT(a_fill_hold, !cmd.execute, $stable(fill_level), "fill level moved without execute")

endmodule

// File: design/min_tracking_stack_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_core
// Bounded LIFO stack of signed words that reports its minimum in constant time.
// ----------------------------------------------------------------------------
// Each transfer on the slave side is one operation: push, pop or peek. Each
// operation yields exactly one result transfer that carries the returned
// value, the minimum after the operation, the empty flag, the entry count and
// a status code. For each operation, the accepting edge reads the top entry
// from the single-port entry memory into a register, and the execute state
// then evaluates the operation, writes a pushed entry and loads the result
// register; a new operation is not accepted before that load. The input is
// taken again as soon as the result is in its register, even while that
// result still waits on m_tready; a result that cannot be loaded because the
// previous one is still held stalls the block in its execute cycle. The
// minimum is tracked with the encoded-minimum method: a push below the
// current minimum stores twice the value less the old minimum, which lets a
// pop recover the previous minimum without a second memory. A push onto a
// full stack is dropped with an overflow status, and a pop or peek on an
// empty stack returns -1 with an underflow status. Kind code 3 acts as a
// peek. The entry memory needs no clearing: only written entries are read.
// ----------------------------------------------------------------------------
module min_tracking_stack_core
  import mts_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // Operation transfers.
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [S_TDATA_WIDTH-1:0] s_tdata,  // [31:0] value
  input  logic [KIND_WIDTH-1:0]    s_tuser,  // [1:0] kind
  // Result transfers.
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // [31:0] result_value, [63:32] min_value, [64] is_empty,
  // [73:65] entry_count, [79:74] zero
  output logic [M_TDATA_WIDTH-1:0] m_tdata,
  output logic [STATUS_WIDTH-1:0]  m_tuser   // [1:0] status
);

  mts_cmd_t                       cmd;
  logic signed [DATA_WIDTH-1:0]   result_value;
  logic signed [DATA_WIDTH-1:0]   min_value;
  logic                           is_empty;
  logic        [COUNT_WIDTH-1:0]  entry_count;

  // The controller sequences accept and execute; the datapath holds all
  // stack state and the result payload.
  mts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  mts_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_kind      (s_tuser),
    .in_value     (s_tdata[DATA_WIDTH-1:0]),
    .result_value (result_value),
    .min_value    (min_value),
    .is_empty     (is_empty),
    .entry_count  (entry_count),
    .status       (m_tuser)
  );

  // Pack the result fields from the lowest bit up and pad to whole bytes.
  assign m_tdata = M_TDATA_WIDTH'({entry_count, is_empty, min_value, result_value});

endmodule

// File: bench/tb_min_tracking_stack_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_tracking_stack_core
// Self-checking bench for the minimum-tracking stack core.
// ----------------------------------------------------------------------------
// Operations are sent as stream transfers on the slave side. As each one is
// accepted, a behavioral copy of the stack predicts the result transfer that
// it must produce. A monitor on the master side compares every result, field
// by field, with the oldest prediction. The run starts with directed checks
// of the empty stack and of extreme values, continues with random mixes of
// push, pop and peek under three patterns of back-pressure, and ends by
// filling the stack to overflow and draining it to underflow.
// ----------------------------------------------------------------------------
module tb_min_tracking_stack_core;
  import mts_pkg::*;

  // The spare kind code is decoded as a peek by the core.
  localparam logic [KIND_WIDTH-1:0] OP_SPARE = 2'd3;
  localparam int CLK_HALF    = 4;
  localparam int RESET_LEN   = 11;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 8;
  localparam int MAX_REPORTS = 20;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] result_value;
    logic signed [DATA_WIDTH-1:0] min_value;
    logic                         is_empty;
    logic [COUNT_WIDTH-1:0]       entry_count;
    logic [STATUS_WIDTH-1:0]      status;
  } stack_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [S_TDATA_WIDTH-1:0] s_tdata = '0;
  logic [KIND_WIDTH-1:0]    s_tuser = OP_PUSH;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [M_TDATA_WIDTH-1:0] m_tdata;
  logic [STATUS_WIDTH-1:0]  m_tuser;

  // Shadow stack: encoded entries, fill level and running minimum.
  logic signed [ENTRY_WIDTH-1:0] shadow_mem [STACK_DEPTH];
  int                            shadow_fill = 0;
  logic signed [DATA_WIDTH-1:0]  shadow_min = '0;

  stack_result_t pending_results[$];

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int error_count   = 0;
  int result_count  = 0;
  int cycle_count   = 0;
  int n_push = 0, n_pop = 0, n_peek = 0, n_encoded = 0;
  int n_overflow = 0, n_underflow = 0, peak_fill = 0;

  min_tracking_stack_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Update the shadow stack for one accepted operation and queue the result
  // that the core has to return for it.
  task automatic apply_stack_op(input logic [KIND_WIDTH-1:0] kind,
                                input logic [DATA_WIDTH-1:0] value);
    stack_result_t                 want;
    logic signed [ENTRY_WIDTH-1:0] val_e;
    logic signed [ENTRY_WIDTH-1:0] min_e;
    logic signed [ENTRY_WIDTH-1:0] top_e;
    logic signed [ENTRY_WIDTH-1:0] restored;
    val_e = $signed(value);
    min_e = shadow_min;
    want.result_value = -1;
    want.status = ST_OK;
    if (kind == OP_PUSH) begin
      n_push++;
      want.result_value = value;
      if (shadow_fill == STACK_DEPTH) begin
        want.status = ST_OVERFLOW;
        n_overflow++;
      end else if (shadow_fill == 0) begin
        shadow_mem[0] = val_e;
        shadow_min = value;
        shadow_fill = 1;
      end else begin
        // A new minimum is stored encoded so that a pop can recover the old one.
        if (val_e < min_e) begin
          shadow_mem[shadow_fill] = 2 * val_e - min_e;
          shadow_min = value;
          n_encoded++;
        end else begin
          shadow_mem[shadow_fill] = val_e;
        end
        shadow_fill++;
      end
    end else begin
      if (kind == OP_POP) n_pop++;
      else n_peek++;
      if (shadow_fill == 0) begin
        want.status = ST_UNDERFLOW;
        n_underflow++;
      end else begin
        top_e = shadow_mem[shadow_fill - 1];
        if (top_e < min_e) begin
          // Encoded entry: the value itself is the current minimum.
          want.result_value = shadow_min;
          if (kind == OP_POP) begin
            restored = 2 * min_e - top_e;
            shadow_min = restored[DATA_WIDTH-1:0];
          end
        end else begin
          want.result_value = top_e[DATA_WIDTH-1:0];
        end
        if (kind == OP_POP) shadow_fill--;
      end
    end
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    want.min_value   = (shadow_fill != 0) ? shadow_min : -1;
    want.is_empty    = (shadow_fill == 0);
    want.entry_count = shadow_fill[COUNT_WIDTH-1:0];
    pending_results.push_back(want);
  endtask

  // Offer one operation, with an optional random gap in front, and wait for
  // its transfer. Valid stays high into the next call unless a gap follows.
  task automatic issue_op(input logic [KIND_WIDTH-1:0] kind,
                          input logic [DATA_WIDTH-1:0] value);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_stack_op(kind, value);
  endtask

  task automatic pause_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Values that favor boundaries and the neighborhood of the running minimum,
  // so that encoded entries and ties with the minimum occur often.
  function automatic logic [DATA_WIDTH-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return shadow_min + $urandom_range(4) - 2;
      5:       return $urandom_range(15) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KIND_WIDTH-1:0] pick_kind();
    int roll;
    roll = $urandom_range(99);
    if (roll < 48) return OP_PUSH;
    if (roll < 84) return OP_POP;
    if (roll < 94) return OP_PEEK;
    return OP_SPARE;
  endfunction

  task automatic test_empty_access();
    issue_op(OP_POP,   $urandom);
    issue_op(OP_PEEK,  $urandom);
    issue_op(OP_SPARE, $urandom);
  endtask

  // Extreme values drive the encoding to the far ends of the widened entry.
  task automatic test_extreme_values();
    issue_op(OP_PUSH,  32'h7FFF_FFFF);
    issue_op(OP_PEEK,  '0);
    issue_op(OP_PUSH,  32'h8000_0000);
    issue_op(OP_PEEK,  '0);
    issue_op(OP_SPARE, '1);
    issue_op(OP_PUSH,  32'h8000_0000);
    issue_op(OP_POP,   '0);
    issue_op(OP_POP,   '0);
    issue_op(OP_POP,   '0);
    issue_op(OP_PUSH,  32'hFFFF_FFFF);
    issue_op(OP_PUSH,  32'h0000_0000);
    issue_op(OP_PUSH,  32'h8000_0000);
    issue_op(OP_PUSH,  32'h8000_0001);
    issue_op(OP_POP,   '0);
    issue_op(OP_PEEK,  '0);
    issue_op(OP_POP,   '0);
    issue_op(OP_POP,   '0);
    issue_op(OP_POP,   '0);
    issue_op(OP_POP,   '0);
    issue_op(OP_PEEK,  '0);
  endtask

  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) begin
      // Sender holds off once mid-run until every result is back.
      if (i == count / 2) pause_until_drained();
      issue_op(pick_kind(), pick_value());
    end
  endtask

  // Fill to the top, push past it, then drain to below the bottom.
  task automatic test_fill_and_drain();
    while (shadow_fill < STACK_DEPTH) issue_op(OP_PUSH, pick_value());
    repeat (3) issue_op(OP_PUSH, $urandom);
    issue_op(OP_PEEK, $urandom);
    issue_op(OP_POP, $urandom);
    issue_op(OP_PUSH, 32'h8000_0000);
    issue_op(OP_PUSH, $urandom);
    while (shadow_fill > 0) begin
      if ($urandom_range(9) == 0) issue_op(OP_SPARE, $urandom);
      else issue_op(OP_POP, $urandom);
    end
    issue_op(OP_POP, $urandom);
  endtask

  // Result side: random back-pressure and the comparison of every transfer.
  always @(posedge clk) begin
    stack_result_t                want;
    stack_result_t                got;
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
    if (!rst && m_tvalid && m_tready) begin
      got.result_value = m_tdata[DATA_WIDTH-1:0];
      got.min_value    = m_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
      got.is_empty     = m_tdata[2*DATA_WIDTH];
      got.entry_count  = m_tdata[2*DATA_WIDTH+COUNT_WIDTH:2*DATA_WIDTH+1];
      got.status       = m_tuser;
      result_count++;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected result transfer: value %0d min %0d count %0d",
                   $time, got.result_value, got.min_value, got.entry_count);
      end else begin
        want = pending_results.pop_front();
        if (got.result_value !== want.result_value || got.min_value !== want.min_value ||
            got.is_empty !== want.is_empty || got.entry_count !== want.entry_count ||
            got.status !== want.status) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: result %0d expected value %0d min %0d empty %0b count %0d status %0d",
                     $time, result_count, want.result_value, want.min_value,
                     want.is_empty, want.entry_count, want.status);
            $display("%0t: result %0d actual   value %0d min %0d empty %0b count %0d status %0d",
                     $time, result_count, got.result_value, got.min_value,
                     got.is_empty, got.entry_count, got.status);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("min_tracking_stack_core: mismatch");
    $finish;
  end

  initial begin
    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sender idles lightly, receiver heavily.
    src_idle_pct  = 26;
    sink_idle_pct = 79;
    test_empty_access();
    test_extreme_values();
    test_random_mix(25);
    pause_until_drained();

    // Roles swapped: results are taken quickly, operations arrive slowly.
    src_idle_pct  = 79;
    sink_idle_pct = 26;
    test_random_mix(25);
    pause_until_drained();

    // Full rate on both sides.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_mix(25);
    test_fill_and_drain();

    pause_until_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() != 0) error_count++;

    $display("Covered %0d pushes (%0d encoded minima), %0d pops, %0d peeks, peak depth %0d.",
             n_push, n_encoded, n_pop, n_peek, peak_fill);
    $display("Saw %0d overflows, %0d underflows, %0d results, %0d errors.",
             n_overflow, n_underflow, result_count, error_count);
    if (error_count == 0) begin
      $display("min_tracking_stack_core: match");
    end else begin
      $display("min_tracking_stack_core: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/mts_pkg.sv
design/mts_ctrl.sv
design/mts_datapath.sv
design/min_tracking_stack_core.sv
bench/tb_min_tracking_stack_core.sv
